// ----- sv/assert_macros.svh -----
// assertion macros used by the rtl
// no dependencies; included by pq_lookup_distance_scan.sv, the one file that checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define PQDS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define PQDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- sv/pqds_pkg.sv -----
// shared constants, codes and types of the pq distance scan
// no dependencies; imported by every module of the block
package pqds_pkg;

   localparam int SUBQUANTIZERS = 32;
   localparam int FRACTION_BITS = 12;

   localparam int CODE_W   = 6;
   localparam int CODEBOOK = 64;
   localparam int ADDR_W   = 11;
   localparam int BANK_W   = ADDR_W - CODE_W;
   localparam int VALUE_W  = 16;
   localparam int OFFSET_W = 24;
   localparam int SCALE_W  = 16;
   localparam int NORM_W   = 8;
   localparam int CODES_W  = 64;
   localparam int SCORE_W  = 32;
   localparam int PROD_W   = SCALE_W + NORM_W;

   // adder tree shape: groups of four per registered level
   localparam int GROUP = 4;
   localparam int G1    = (SUBQUANTIZERS + GROUP - 1) / GROUP;
   localparam int G2    = (G1 + GROUP - 1) / GROUP;
   localparam int P1_W  = VALUE_W + 2;
   localparam int P2_W  = P1_W + 2;
   localparam int SUM_W = ((P2_W > OFFSET_W) ? P2_W : OFFSET_W) + 2;

   // command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_SCORE = 1'b1;

   // register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_OFFSET = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORM_SCALE   = 1'b1;

   typedef logic signed [VALUE_W-1:0] lane_value_type;

   typedef struct packed {
      logic                wr_en;
      logic [CODE_W-1:0]   wr_addr;
      lane_value_type      wr_data;
      logic                rd_en;
      logic [CODE_W-1:0]   rd_addr;
   } lane_ctl_type;

endpackage

// ----- sv/pqds_lane.sv -----
// one lane: the 64-entry table bank of one subquantizer with registered read
// depends on pqds_pkg
module pqds_lane (
   input  logic                   clock,
   input  pqds_pkg::lane_ctl_type ctl,
   output pqds_pkg::lane_value_type rd_data
);
   import pqds_pkg::*;

   lane_value_type mem [CODEBOOK];
   lane_value_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/pqds_merge.sv -----
// merging stage: registered adder tree over the lane values plus offset and norm term
// depends on pqds_pkg
module pqds_merge (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    s1_valid,
   output logic                                    s1_ready,
   input  pqds_pkg::lane_value_type                lane_data [pqds_pkg::SUBQUANTIZERS],
   input  logic signed [pqds_pkg::PROD_W-1:0]      prod,
   input  logic signed [pqds_pkg::OFFSET_W-1:0]    offset,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [pqds_pkg::SCORE_W-1:0]     rsp_score
);
   import pqds_pkg::*;

   logic v2_ff, v3_ff, rsp_valid_ff;
   logic s2_en, s3_en, out_en;

   logic signed [P1_W-1:0]  p1_in [G1];
   logic signed [P1_W-1:0]  p1_ff [G1];
   logic signed [P2_W-1:0]  p2_in [G2];
   logic signed [P2_W-1:0]  p2_ff [G2];
   logic signed [SUM_W-1:0] base_in, base_ff, base2_ff;
   logic signed [SUM_W-1:0] total_in;
   logic signed [PROD_W-1:0] prod_sh;
   logic signed [SCORE_W-1:0] score_ff;

   // bubbles collapse: a stage loads when it is empty or its successor moves
   assign out_en   = !rsp_valid_ff || rsp_ready;
   assign s3_en    = !v3_ff || out_en;
   assign s2_en    = !v2_ff || s3_en;
   assign s1_ready = s2_en;

   assign prod_sh = prod >>> FRACTION_BITS;
   assign base_in = SUM_W'(offset) + SUM_W'(prod_sh);

   always_comb begin
      for (int g = 0; g < G1; g++) begin
         p1_in[g] = '0;
         for (int k = 0; k < GROUP; k++) begin
            if (g * GROUP + k < SUBQUANTIZERS) begin
               p1_in[g] = p1_in[g] + P1_W'(lane_data[g * GROUP + k]);
            end
         end
      end
   end

   always_comb begin
      for (int g = 0; g < G2; g++) begin
         p2_in[g] = '0;
         for (int k = 0; k < GROUP; k++) begin
            if (g * GROUP + k < G1) begin
               p2_in[g] = p2_in[g] + P2_W'(p1_ff[g * GROUP + k]);
            end
         end
      end
   end

   always_comb begin
      total_in = base2_ff;
      for (int g = 0; g < G2; g++) begin
         total_in = total_in + SUM_W'(p2_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s2_en) begin
            v2_ff <= s1_valid;
         end
         if (s3_en) begin
            v3_ff <= v2_ff;
         end
         if (out_en) begin
            rsp_valid_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         p1_ff   <= p1_in;
         base_ff <= base_in;
      end
      if (s3_en) begin
         p2_ff    <= p2_in;
         base2_ff <= base_ff;
      end
      if (out_en) begin
         // the sum range lies well inside 32 bits, so the resize to SCORE_W loses nothing
         score_ff <= SCORE_W'(total_in);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_score = score_ff;

endmodule

// ----- sv/pq_lookup_distance_scan.sv -----
// top level of the product-quantization distance scan
// depends on pqds_pkg, pqds_lane, pqds_merge and assert_macros.svh
// usage
//   req channel: one transfer per command. req_command = write stores
//   req_table_value at req_table_address (bank = address bits 10:6, entry =
//   bits 5:0) and gives no response. req_command = score carries one row of
//   32 packed 6-bit codes and a norm code and gives exactly one rsp transfer.
//   rsp_score = score_offset + ((norm_scale * norm_code) >>> 12)
//               + sum of the 32 selected table entries
//   csr port: csr_we writes csr_wdata into register csr_index (0 offset,
//   1 scale); the user must write only while no row is in flight (unenforced).
// pipeline and throughput
//   one item per cycle while req_ready is high. a score row is read from the
//   32 lane banks at its transfer, then passes two adder-tree levels and the
//   output register before rsp_valid rises. a table write takes effect for
//   the very next row.
// reset
//   clears the pipeline valids and both config registers; the table holds
//   garbage until written, and rows must only address written entries.
// stalls
//   each stage loads when empty, so req_ready stays high while bubbles
//   remain even if rsp_ready is low; it drops once all four stages hold rows.
`include "assert_macros.svh"

module pq_lookup_distance_scan (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_command,
   input  logic [pqds_pkg::ADDR_W-1:0]              req_table_address,
   input  logic signed [pqds_pkg::VALUE_W-1:0]      req_table_value,
   input  logic [pqds_pkg::CODES_W-1:0]             req_codes_low,
   input  logic [pqds_pkg::CODES_W-1:0]             req_codes_mid,
   input  logic [pqds_pkg::CODES_W-1:0]             req_codes_high,
   input  logic [pqds_pkg::NORM_W-1:0]              req_norm_code,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [pqds_pkg::SCORE_W-1:0]      rsp_score,
   input  logic                                     csr_we,
   input  logic [pqds_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [pqds_pkg::OFFSET_W-1:0]            csr_wdata
);
   import pqds_pkg::*;

   // config registers
   logic signed [OFFSET_W-1:0] offset_ff;
   logic signed [SCALE_W-1:0]  scale_ff;

   // stage 1: lane reads and the norm product land here
   logic                       s1_valid_ff;
   logic                       s1_ready;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [PROD_W-1:0]   scale_ext, norm_ext;

   logic                       req_xfer;
   logic [3*CODES_W-1:0]       codes_all;
   lane_ctl_type               lane_ctl  [SUBQUANTIZERS];
   lane_value_type             lane_data [SUBQUANTIZERS];

   assign req_ready = !s1_valid_ff || s1_ready;
   assign req_xfer  = req_valid && req_ready;
   assign codes_all = {req_codes_high, req_codes_mid, req_codes_low};

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         scale_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCORE_OFFSET: offset_ff <= csr_wdata;
            CSR_NORM_SCALE:   scale_ff  <= csr_wdata[SCALE_W-1:0];
            default:          ;
         endcase
      end
   end

   // norm term, signed scale times unsigned code
   assign scale_ext = PROD_W'(scale_ff);
   assign norm_ext  = PROD_W'(req_norm_code);
   assign prod_in   = scale_ext * norm_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_xfer && (req_command == CMD_SCORE);
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         prod_ff <= prod_in;
      end
   end

   // one lane per subquantizer, each owns its 64-entry bank
   for (genvar g = 0; g < SUBQUANTIZERS; g++) begin : g_lane
      always_comb begin
         lane_ctl[g].wr_en   = req_xfer && (req_command == CMD_WRITE)
                               && (req_table_address[ADDR_W-1:CODE_W] == BANK_W'(g));
         lane_ctl[g].wr_addr = req_table_address[CODE_W-1:0];
         lane_ctl[g].wr_data = req_table_value;
         lane_ctl[g].rd_en   = req_ready;
         lane_ctl[g].rd_addr = codes_all[g*CODE_W +: CODE_W];
      end

      pqds_lane u_lane (
         .clock   (clock),
         .ctl     (lane_ctl[g]),
         .rd_data (lane_data[g])
      );
   end

   pqds_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid_ff),
      .s1_ready  (s1_ready),
      .lane_data (lane_data),
      .prod      (prod_ff),
      .offset    (offset_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_score (rsp_score)
   );

   // a table write never enters the scoring pipeline
   `PQDS_ASSERT_NEXT(a_write_no_row, clock, reset,
      req_xfer && (req_command == CMD_WRITE), !s1_valid_ff)
   // an accepted score row always occupies stage 1 next cycle
   `PQDS_ASSERT_NEXT(a_score_enters, clock, reset,
      req_xfer && (req_command == CMD_SCORE), s1_valid_ff)
   // an empty first stage never blocks the request side
   `PQDS_ASSERT_IMPL(a_no_false_stall, clock, reset, !s1_valid_ff, req_ready)

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// testbench for pq_lookup_distance_scan: directed and random table writes and row scores,
// each score checked against a score predictor kept inside the bench
// depends on pqds_pkg and the pq_lookup_distance_scan rtl
module tb;
   import pqds_pkg::*;

   localparam int TABLE_DEPTH  = 1 << ADDR_W;
   localparam int ROW_W        = SUBQUANTIZERS * CODE_W;
   localparam int IDLE_PCT     = 23;
   localparam int WRITE_PCT    = 30;
   localparam int DRAIN_CYCLES = 8;    // pipeline is 4 deep, allow some slack
   localparam int HOLD_CYCLES  = 80;
   localparam int REPORT_MAX   = 10;
   localparam longint SCORE_MAX = (longint'(1) << (SCORE_W - 1)) - 1;
   localparam longint SCORE_MIN = -(longint'(1) << (SCORE_W - 1));

   typedef struct {
      logic                      command;
      logic [ADDR_W-1:0]         table_address;
      logic signed [VALUE_W-1:0] table_value;
      logic [CODES_W-1:0]        codes_low;
      logic [CODES_W-1:0]        codes_mid;
      logic [CODES_W-1:0]        codes_high;
      logic [NORM_W-1:0]         norm_code;
   } scan_req_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_command;
   logic [ADDR_W-1:0]         req_table_address;
   logic signed [VALUE_W-1:0] req_table_value;
   logic [CODES_W-1:0]        req_codes_low;
   logic [CODES_W-1:0]        req_codes_mid;
   logic [CODES_W-1:0]        req_codes_high;
   logic [NORM_W-1:0]         req_norm_code;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [SCORE_W-1:0] rsp_score;
   logic                      csr_we;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [OFFSET_W-1:0]       csr_wdata;

   // mirror of the block state, updated at each table write transfer or register write
   logic signed [VALUE_W-1:0] table_mirror [TABLE_DEPTH];
   logic [CODEBOOK-1:0]       written_mask [SUBQUANTIZERS];
   longint                    offset_mirror;
   longint                    scale_mirror;

   logic signed [SCORE_W-1:0] score_expect_q [$];
   int                        mismatch_count;

   // traffic shaping knobs
   bit req_gaps_on;
   bit rsp_gaps_on;
   bit hold_off_req;

   pq_lookup_distance_scan dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_table_address (req_table_address),
      .req_table_value   (req_table_value),
      .req_codes_low     (req_codes_low),
      .req_codes_mid     (req_codes_mid),
      .req_codes_high    (req_codes_high),
      .req_norm_code     (req_norm_code),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_score         (rsp_score),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // generous run limit, far above the slowest legal run
   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // ------------------------------------------------------------------
   // score predictor
   // ------------------------------------------------------------------

   // offset + floored scale*norm + one table entry per subquantizer, then saturate.
   // with these widths the sum never reaches the 32-bit limits, the clamp stays anyway
   function automatic logic signed [SCORE_W-1:0] predict_score(input scan_req_type it);
      logic [ROW_W-1:0] row_codes;
      longint           acc;
      int               entry;
      row_codes = {it.codes_high, it.codes_mid, it.codes_low};
      // >>> on a signed longint floors, which matches the arithmetic shift
      acc = offset_mirror + ((scale_mirror * longint'(it.norm_code)) >>> FRACTION_BITS);
      for (int m = 0; m < SUBQUANTIZERS; m++) begin
         entry = m * CODEBOOK + int'(row_codes[m*CODE_W +: CODE_W]);
         acc += longint'(table_mirror[entry]);
      end
      if (acc > SCORE_MAX) begin
         acc = SCORE_MAX;
      end else if (acc < SCORE_MIN) begin
         acc = SCORE_MIN;
      end
      return acc[SCORE_W-1:0];
   endfunction

   // ------------------------------------------------------------------
   // item builders
   // ------------------------------------------------------------------

   function automatic logic [CODES_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic signed [VALUE_W-1:0] random_value();
      int pick;
      pick = $urandom_range(7);
      if (pick == 0) return {1'b1, {(VALUE_W-1){1'b0}}};
      if (pick == 1) return {1'b0, {(VALUE_W-1){1'b1}}};
      return VALUE_W'($urandom);
   endfunction

   // row fields are junk on a write, the block must ignore them
   function automatic scan_req_type make_write(input logic [ADDR_W-1:0] addr,
                                               input logic signed [VALUE_W-1:0] value);
      scan_req_type it;
      it.command       = CMD_WRITE;
      it.table_address = addr;
      it.table_value   = value;
      it.codes_low     = random_word();
      it.codes_mid     = random_word();
      it.codes_high    = random_word();
      it.norm_code     = NORM_W'($urandom);
      return it;
   endfunction

   // address and value are junk on a score row
   function automatic scan_req_type make_row(input logic [ROW_W-1:0] codes,
                                             input logic [NORM_W-1:0] norm);
      scan_req_type it;
      it.command       = CMD_SCORE;
      it.table_address = ADDR_W'($urandom);
      it.table_value   = VALUE_W'($urandom);
      it.codes_low     = codes[CODES_W-1:0];
      it.codes_mid     = codes[2*CODES_W-1:CODES_W];
      it.codes_high    = codes[3*CODES_W-1:2*CODES_W];
      it.norm_code     = norm;
      return it;
   endfunction

   // only entries written since reset may be addressed by a row
   function automatic logic [ROW_W-1:0] pick_written_codes();
      logic [ROW_W-1:0] codes;
      int               cands[$];
      for (int m = 0; m < SUBQUANTIZERS; m++) begin
         cands.delete();
         for (int c = 0; c < CODEBOOK; c++) begin
            if (written_mask[m][c]) cands.push_back(c);
         end
         codes[m*CODE_W +: CODE_W] = CODE_W'(cands[$urandom_range(cands.size() - 1)]);
      end
      return codes;
   endfunction

   function automatic scan_req_type make_random_item();
      int kind;
      if ($urandom_range(99) < WRITE_PCT) begin
         return make_write(ADDR_W'($urandom), random_value());
      end
      kind = $urandom_range(19);
      if (kind == 0) return make_row({SUBQUANTIZERS{6'd0}}, NORM_W'($urandom));
      if (kind == 1) return make_row({SUBQUANTIZERS{6'd63}}, NORM_W'($urandom));
      return make_row(pick_written_codes(), NORM_W'($urandom));
   endfunction

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------

   // offers one item and returns right after the edge of its transfer
   task automatic send_item(input scan_req_type it);
      while (req_gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= it.command;
      req_table_address <= it.table_address;
      req_table_value   <= it.table_value;
      req_codes_low     <= it.codes_low;
      req_codes_mid     <= it.codes_mid;
      req_codes_high    <= it.codes_high;
      req_norm_code     <= it.norm_code;
      do @(posedge clock); while (!req_ready);
      // transfer happened at this edge
      if (it.command == CMD_WRITE) begin
         table_mirror[it.table_address] = it.table_value;
         written_mask[it.table_address[ADDR_W-1:CODE_W]][it.table_address[CODE_W-1:0]] = 1'b1;
      end else begin
         score_expect_q.push_back(predict_score(it));
      end
   endtask

   // wait for every pending score, then let a trailing write settle
   task automatic drain_rsp();
      req_valid <= 1'b0;
      while (score_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // both registers, one per cycle; only called with the block idle
   task automatic set_config(input logic signed [OFFSET_W-1:0] offset,
                             input logic signed [SCALE_W-1:0] scale);
      logic [OFFSET_W-SCALE_W-1:0] pad;
      pad = (OFFSET_W-SCALE_W)'($urandom);   // bits above the scale field are don't-care
      csr_we    <= 1'b1;
      csr_index <= CSR_SCORE_OFFSET;
      csr_wdata <= offset;
      @(posedge clock);
      offset_mirror = longint'(offset);
      csr_index <= CSR_NORM_SCALE;
      csr_wdata <= {pad, scale};
      @(posedge clock);
      scale_mirror = longint'(scale);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // response side: random ready, long hold-off on request
   // ------------------------------------------------------------------

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
            rsp_ready <= 1'b1;
         end else if (rsp_gaps_on && $urandom_range(99) < IDLE_PCT) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare every response transfer with the oldest pending score
   always @(posedge clock) begin : check_rsp
      logic signed [SCORE_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (score_expect_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("%0t: score %0d with no row pending", $realtime, rsp_score);
         end else begin
            want = score_expect_q.pop_front();
            if (rsp_score !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("%0t: score mismatch, expected %0d got %0d",
                           $realtime, want, rsp_score);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // code 0 and code 63 of every bank, at the two value extremes
   task automatic test_preload();
      for (int m = 0; m < SUBQUANTIZERS; m++) begin
         send_item(make_write(ADDR_W'(m * CODEBOOK), {1'b1, {(VALUE_W-1){1'b0}}}));
         send_item(make_write(ADDR_W'(m * CODEBOOK + CODEBOOK - 1),
                              {1'b0, {(VALUE_W-1){1'b1}}}));
      end
   endtask

   // rows under the config left by reset (offset 0, scale 0)
   task automatic test_reset_defaults();
      send_item(make_row({SUBQUANTIZERS{6'd0}}, 8'd255));
      send_item(make_row({SUBQUANTIZERS{6'd63}}, 8'd0));
   endtask

   // register and norm extremes, all-zero and all-ones code rows
   task automatic test_config_extremes();
      drain_rsp();
      set_config({1'b0, {(OFFSET_W-1){1'b1}}}, {1'b0, {(SCALE_W-1){1'b1}}});
      send_item(make_row({SUBQUANTIZERS{6'd63}}, 8'd255));
      send_item(make_row({SUBQUANTIZERS{6'd0}}, 8'd0));
      drain_rsp();
      set_config({1'b1, {(OFFSET_W-1){1'b0}}}, {1'b1, {(SCALE_W-1){1'b0}}});
      send_item(make_row({SUBQUANTIZERS{6'd0}}, 8'd255));
      send_item(make_row({SUBQUANTIZERS{6'd63}}, 8'd1));
   endtask

   // negative products must floor, not truncate toward zero
   task automatic test_floor_shift();
      drain_rsp();
      set_config('0, -16'sd1);
      send_item(make_row({SUBQUANTIZERS{6'd0}}, 8'd1));
      send_item(make_row({SUBQUANTIZERS{6'd63}}, 8'd255));
      drain_rsp();
      set_config(24'sd4096, 16'sd4095);
      send_item(make_row({SUBQUANTIZERS{6'd63}}, 8'd1));
   endtask

   // a table write is seen by the very next row; codes straddle word edges
   task automatic test_write_then_score();
      send_item(make_write(ADDR_W'(7 * CODEBOOK + CODEBOOK - 1), 16'sh1234));
      send_item(make_row({SUBQUANTIZERS{6'd63}}, 8'h5a));
      send_item(make_write('0, -16'sd1));
      send_item(make_row({SUBQUANTIZERS{6'd0}}, 8'ha5));
      send_item(make_row({(SUBQUANTIZERS/2){6'd63, 6'd0}}, 8'h0f));
      send_item(make_row({(SUBQUANTIZERS/2){6'd0, 6'd63}}, 8'hf0));
   endtask

   task automatic test_random_scan(input int count);
      repeat (count) send_item(make_random_item());
   endtask

   // every random phase starts from a fresh register setting
   task automatic test_random_config(input int count);
      drain_rsp();
      set_config(OFFSET_W'($urandom), SCALE_W'($urandom));
      test_random_scan(count);
   endtask

   // back-to-back traffic on both sides
   task automatic test_no_idle_burst(input int count);
      drain_rsp();
      set_config(OFFSET_W'($urandom), SCALE_W'($urandom));
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      test_random_scan(count);
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // receiver stops while rows keep coming, so the pipeline fills and req_ready drops
   task automatic test_output_hold_off(input int count);
      drain_rsp();
      req_gaps_on  = 1'b0;
      hold_off_req = 1'b1;
      repeat (count) send_item(make_row(pick_written_codes(), NORM_W'($urandom)));
      req_gaps_on = 1'b1;
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_command       = CMD_WRITE;
      req_table_address = '0;
      req_table_value   = '0;
      req_codes_low     = '0;
      req_codes_mid     = '0;
      req_codes_high    = '0;
      req_norm_code     = '0;
      csr_we            = 1'b0;
      csr_index         = CSR_SCORE_OFFSET;
      csr_wdata         = '0;
      offset_mirror     = 0;
      scale_mirror      = 0;
      mismatch_count    = 0;
      req_gaps_on       = 1'b1;
      rsp_gaps_on       = 1'b1;
      hold_off_req      = 1'b0;
      for (int m = 0; m < SUBQUANTIZERS; m++) written_mask[m] = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_preload();
      test_reset_defaults();
      test_config_extremes();
      test_floor_shift();
      test_write_then_score();

      test_random_config(150);
      test_random_config(150);
      drain_rsp();
      set_config({1'b0, {(OFFSET_W-1){1'b1}}}, {1'b1, {(SCALE_W-1){1'b0}}});
      test_random_scan(120);
      test_no_idle_burst(150);
      test_output_hold_off(40);
      drain_rsp();
      set_config({1'b1, {(OFFSET_W-1){1'b0}}}, {1'b0, {(SCALE_W-1){1'b1}}});
      test_random_scan(120);
      test_random_config(80);

      drain_rsp();
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
